/* rtl/fpmt_pkg.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: shared package
// Field widths, item kind codes and the structs exchanged between the
// walk sequencer and the shared step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpmt_pkg;

	// Field widths of the item, result and configuration channels.
	localparam int KIND_W = 2;
	localparam int POS_W  = 11;
	localparam int VAL_W  = 16;
	localparam int SIZE_W = 11;

	// A walk position needs one bit more than a tree position, since an
	// upward step from a valid node can overshoot to up to twice its number.
	localparam int WALK_W = POS_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// Item kind codes.
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// Control going into the step unit for the node currently on the walk.
	typedef struct packed {
		logic [WALK_W-1:0] x;        // current node number
		logic              down;     // 1 for a query walk, 0 for an update walk
		logic              rd_valid; // valid bit read for this node
		logic              found;    // query has met a valid node already
	} step_ctl_t;

	// Status coming back from the step unit.
	typedef struct packed {
		logic [WALK_W-1:0] next_x;   // next node on the walk
		logic              take;     // node value replaced (update) or taken (query)
	} step_res_t;

endpackage

`default_nettype wire

/* rtl/fpmt_if.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: channel interfaces
// Valid/ready channels for items, results and the size register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpmt_in_if;
	logic                       valid;
	logic                       ready;
	logic [fpmt_pkg::KIND_W-1:0] kind;
	logic [fpmt_pkg::POS_W-1:0]  position;
	logic [fpmt_pkg::VAL_W-1:0]  value;

	modport source (output valid, output kind, output position, output value, input ready);
	modport sink (input valid, input kind, input position, input value, output ready);
endinterface

interface fpmt_out_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [fpmt_pkg::VAL_W-1:0] minimum;

	modport source (output valid, output found, output minimum, input ready);
	modport sink (input valid, input found, input minimum, output ready);
endinterface

interface fpmt_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [fpmt_pkg::SIZE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/fpmt_node_ram.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: node memory
// One write port and one read port with registered read data. Each word
// holds a valid bit above the stored minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmt_node_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 17,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/fpmt_step_unit.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: shared step unit
// One adder that moves the walk by the lowest set bit, up or down, and one
// magnitude comparator that decides whether the current node is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmt_step_unit #(
	parameter int VALUE_BITS = 16
) (
	input  wire fpmt_pkg::step_ctl_t       ctl,
	input  wire logic [VALUE_BITS-1:0]     rd_value,
	input  wire logic [VALUE_BITS-1:0]     best,
	input  wire logic [VALUE_BITS-1:0]     val,
	output fpmt_pkg::step_res_t            res
);

	import fpmt_pkg::*;

	logic [WALK_W-1:0]     low_bit;
	logic [WALK_W-1:0]     addend;
	logic [VALUE_BITS-1:0] lhs;
	logic [VALUE_BITS-1:0] rhs;
	logic                  less;

	// Next node: add the lowest set bit going up, subtract it going down.
	// The shared comparator checks the offered value against the stored one
	// on an update, and the stored value against the running best on a query.
	always_comb begin
		low_bit    = ctl.x & (~ctl.x + WALK_W'(1));
		addend     = ctl.down ? (~low_bit + WALK_W'(1)) : low_bit;
		res.next_x = ctl.x + addend;
		lhs        = ctl.down ? rd_value : val;
		rhs        = ctl.down ? best : rd_value;
		less       = lhs < rhs;
		if (ctl.down) begin
			res.take = ctl.rd_valid && (!ctl.found || less);
		end else begin
			res.take = !ctl.rd_valid || less;
		end
	end

endmodule

`default_nettype wire

/* rtl/fenwick_prefix_min_tree.sv */
// An update or query walks the tree one node per cycle, reading each node from the node memory,
// then registers its result in the reply state; a clear first sweeps the whole node memory.
// Throughput: one item at a time; ready is low from acceptance until the result is registered.
// Reset: asynchronous, active low; afterwards a sweep clears all valid bits with
// ready low, and the size register returns to 1024 (writes are taken during the sweep).
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: top level
// Binary indexed tree of prefix minima. A small sequencer walks the tree one
// node per cycle through the node memory and the shared step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_prefix_min_tree #(
	parameter int DEPTH      = 1024,
	parameter int VALUE_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fpmt_in_if.sink     item,
	fpmt_out_if.source  result,
	fpmt_cfg_if.sink    cfg
);

	import fpmt_pkg::*;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int WORD_W = VALUE_BITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SWEEP,
		ST_REPLY
	} state_t;

	state_t                state_q;
	logic [WALK_W-1:0]     x_q;
	logic                  is_query_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] best_q;
	logic                  found_q;
	logic [IDX_W-1:0]      sweep_cnt_q;
	logic                  sweep_reply_q;
	logic [SIZE_W-1:0]     size_q;
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [VAL_W-1:0]      out_min_q;

	logic [WALK_W-1:0]     bound;
	logic                  walk_end;
	logic                  node_ok;
	logic [WORD_W-1:0]     rd_word;
	logic [VALUE_BITS-1:0] rd_value;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [WORD_W-1:0]     wr_data;
	step_ctl_t             step_ctl;
	step_res_t             step_res;
	logic                  item_fire;

	// Handshakes.
	assign item.ready     = (state_q == ST_IDLE);
	assign item_fire      = item.valid && item.ready;
	assign cfg.ready      = 1'b1;
	assign result.valid   = out_valid_q;
	assign result.found   = out_found_q;
	assign result.minimum = out_min_q;

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			size_q <= cfg.data;
		end
	end

	// Walk bound of updates and end-of-walk detection.
	always_comb begin
		bound    = (32'(size_q) < 32'(DEPTH)) ? WALK_W'(size_q) : WALK_W'(DEPTH);
		walk_end = (x_q == '0) || (!is_query_q && (x_q > bound));
		node_ok  = !walk_end && (32'(x_q) <= 32'(DEPTH));
	end

	// Node memory and the shared step unit.
	assign rd_value = rd_word[VALUE_BITS-1:0];

	always_comb begin
		step_ctl.x        = x_q;
		step_ctl.down     = is_query_q;
		step_ctl.rd_valid = rd_word[VALUE_BITS];
		step_ctl.found    = found_q;
	end

	fpmt_step_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.ctl      (step_ctl),
		.rd_value (rd_value),
		.best     (best_q),
		.val      (val_q),
		.res      (step_res)
	);

	fpmt_node_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (WORD_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// Read address: the first node at acceptance, then the next node while walking,
	// so that each node's word arrives in the cycle it is evaluated.
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = IDX_W'(WALK_W'(item.position) - WALK_W'(1));
			end
			ST_WALK: begin
				rd_addr = IDX_W'(step_res.next_x - WALK_W'(1));
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// Write port: the clearing sweep, or a lowered minimum on an update walk.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_cnt_q;
		wr_data = '0;
		if (state_q == ST_SWEEP) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WALK && node_ok && !is_query_q && step_res.take) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(x_q - WALK_W'(1));
			wr_data = {1'b1, val_q};
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			sweep_cnt_q   <= '0;
			sweep_reply_q <= 1'b0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			// A taken result is dropped here; the reply state loads the next one itself.
			if (result.ready && state_q != ST_REPLY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						x_q        <= WALK_W'(item.position);
						is_query_q <= (item.kind == KIND_QUERY);
						val_q      <= VALUE_BITS'(item.value);
						best_q     <= '0;
						found_q    <= 1'b0;
						unique case (item.kind)
							KIND_UPDATE, KIND_QUERY: begin
								state_q <= ST_WALK;
							end
							KIND_CLEAR: begin
								sweep_cnt_q   <= '0;
								sweep_reply_q <= 1'b1;
								state_q       <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_REPLY;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_end) begin
						state_q <= ST_REPLY;
					end else begin
						if (node_ok && is_query_q && step_res.take) begin
							best_q  <= rd_value;
							found_q <= 1'b1;
						end
						x_q <= step_res.next_x;
					end
				end
				ST_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
					if (sweep_cnt_q == IDX_W'(DEPTH - 1)) begin
						state_q       <= sweep_reply_q ? ST_REPLY : ST_IDLE;
						sweep_reply_q <= 1'b0;
					end
				end
				ST_REPLY: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= found_q;
						out_min_q   <= VAL_W'(best_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/fpmt_checker.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: port checker
// Concurrent assertions on the top-level ports, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmt_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       out_found,
	input wire logic [fpmt_pkg::VAL_W-1:0] out_minimum
);

	import fpmt_pkg::*;

	// The block works on one item at a time: it is busy right after a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready stayed high after an accepted transaction");

	// A new result is only produced while the block was not taking items.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

	// A result that is not found carries a zero minimum.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_found) |-> (out_minimum == '0))
		else $error("minimum is nonzero on a not-found result");

	// A stalled result holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_found) && $stable(out_minimum)))
		else $error("stalled result changed");

endmodule

bind fenwick_prefix_min_tree fpmt_checker u_fpmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_found   (result.found),
	.out_minimum (result.minimum)
);

`default_nettype wire

/* tb/sv/fenwick_prefix_min_tree_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: result checker
// Watches the item, result and size channels, keeps its own copy of the tree
// and of the size register, predicts one answer per accepted item and compares
// every returned answer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fenwick_prefix_min_tree_check (
	input  wire logic clk,
	input  wire logic arst_n,
	fpmt_in_if        item,
	fpmt_out_if       result,
	fpmt_cfg_if       cfg,
	output int        fail_count,
	output int        pending
);
	import fpmt_pkg::*;

	localparam int TREE_DEPTH  = 1024;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] minimum;
	} answer_t;

	// Shadow copy of the tree and of the size register.
	logic [VAL_W-1:0]  node_min [TREE_DEPTH];
	bit                node_set [TREE_DEPTH];
	logic [SIZE_W-1:0] size_reg;

	answer_t answers_due [$];
	int      mismatches;

	// Lower the stored minima along the upward walk, bounded by the size in use.
	function automatic void lower_path(int unsigned pos, logic [VAL_W-1:0] val);
		int unsigned bound;
		int unsigned x;
		bound = (size_reg < TREE_DEPTH) ? size_reg : TREE_DEPTH;
		x = pos;
		while (x != 0 && x <= bound) begin
			if (!node_set[x-1] || val < node_min[x-1]) begin
				node_min[x-1] = val;
				node_set[x-1] = 1'b1;
			end
			x += x & (~x + 1);
		end
	endfunction

	// Minimum of the valid nodes on the downward walk; nodes past the tree are skipped.
	function automatic answer_t prefix_min(int unsigned pos);
		answer_t     a;
		int unsigned x;
		a = '0;
		x = pos;
		while (x != 0) begin
			if (x <= TREE_DEPTH && node_set[x-1]
					&& (!a.found || node_min[x-1] < a.minimum)) begin
				a.found   = 1'b1;
				a.minimum = node_min[x-1];
			end
			x -= x & (~x + 1);
		end
		return a;
	endfunction

	// Apply one item to the shadow tree and return the answer it must produce.
	function automatic answer_t apply_item(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
			logic [VAL_W-1:0] v);
		answer_t a;
		a = '0;
		case (k)
			KIND_UPDATE: lower_path(p, v);
			KIND_QUERY: a = prefix_min(p);
			KIND_CLEAR: foreach (node_set[i]) node_set[i] = 1'b0;
			default: ;
		endcase
		return a;
	endfunction

	// Sample every channel at the clock edge; results are checked before the
	// new item is predicted, since they always belong to an older transaction.
	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			foreach (node_set[i]) node_set[i] = 1'b0;
			size_reg = SIZE_RESET;
			answers_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				size_reg = cfg.data;
			if (result.valid && result.ready) begin
				got = '{found: result.found, minimum: result.minimum};
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result with none expected: found=%0b minimum=%h",
							$realtime, got.found, got.minimum);
				end else begin
					want = answers_due.pop_front();
					if (got.found !== want.found || got.minimum !== want.minimum) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: mismatch: expected found=%0b minimum=%h, ",
								"got found=%0b minimum=%h"},
								$realtime, want.found, want.minimum,
								got.found, got.minimum);
					end
				end
			end
			if (item.valid && item.ready)
				answers_due.insert(answers_due.size(),
					apply_item(item.kind, item.position, item.value));
			fail_count <= mismatches;
			pending <= answers_due.size();
		end
	end

endmodule

/* tb/sv/fenwick_prefix_min_tree_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fenwick prefix-minimum tree: testbench top
// Drives directed and random updates, queries, clears and unused kinds under several size
// settings, with random idling on both channels, and reports the verdict from
// the failure count of the checker.
// ----------------------------------------------------------------------------
module fenwick_prefix_min_tree_tb;
	import fpmt_pkg::*;

	localparam int STALL_LIMIT   = 5000; // well above a clear or the reset sweep
	localparam int SETTLE_CYCLES = 40;   // longer than the slowest walk
	localparam int TREE_DEPTH    = 1024;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	bit   calm;
	int   fail_count;
	int   pending;
	int   quiet;

	fpmt_in_if  item ();
	fpmt_out_if result ();
	fpmt_cfg_if cfg ();

	fenwick_prefix_min_tree DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	fenwick_prefix_min_tree_check prefix_min_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random unless a calm stretch is running.
	always @(posedge clk) begin
		result.ready <= calm || ($urandom_range(99) >= 7);
	end

	// Watchdog on cycles in which no transaction completes on any channel.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet + 1 >= STALL_LIMIT) begin
			$display("fenwick_prefix_min_tree verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offer one item, with an occasional idle gap ahead of it.
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		if (!calm && $urandom_range(99) < 7) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item.valid    <= 1'b1;
		item.kind     <= k;
		item.position <= p;
		item.value    <= v;
		do @(posedge clk); while (!item.ready);
	endtask

	// Stop sending and wait until every predicted answer has come back.
	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Change the size register while the block is idle.
	task automatic write_size(input logic [SIZE_W-1:0] sz);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= sz;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Positions mostly inside the walk bound, some at zero, at the edge and beyond.
	function automatic logic [POS_W-1:0] pick_position(int unsigned bound);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		if (r < 12 || bound == 0)
			return POS_W'($urandom_range(2047, 1));
		if (r < 20)
			return POS_W'($urandom_range(2047, bound));
		return POS_W'($urandom_range(bound, 1));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 40)
			return VAL_W'($urandom_range(31));
		return VAL_W'($urandom());
	endfunction

	// One random phase under a given size setting; optionally drains halfway.
	task automatic run_phase(input logic [SIZE_W-1:0] sz, input int count, input bit hold_mid);
		int unsigned bound;
		int unsigned r;
		logic [KIND_W-1:0] k;
		write_size(sz);
		bound = (sz < TREE_DEPTH) ? sz : TREE_DEPTH;
		for (int n = 0; n < count; n++) begin
			if (hold_mid && n == count / 2)
				drain();
			r = $urandom_range(99);
			if (r < 52)
				k = KIND_UPDATE;
			else if (r < 91)
				k = KIND_QUERY;
			else if (r < 96)
				k = KIND_CLEAR;
			else
				k = KIND_UNUSED;
			send_item(k, pick_position(bound), pick_value());
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n        = 1'b0;
		calm          = 1'b0;
		quiet         = 0;
		item.valid    = 1'b0;
		item.kind     = KIND_UPDATE;
		item.position = '0;
		item.value    = '0;
		result.ready  = 1'b1;
		cfg.valid     = 1'b0;
		cfg.data      = SIZE_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items under the size set at reset.
		send_item(KIND_QUERY, 11'd5, 16'h0000);     // empty tree
		send_item(KIND_UPDATE, 11'd0, 16'h0007);    // position zero does nothing
		send_item(KIND_QUERY, 11'd0, 16'h0000);
		send_item(KIND_UPDATE, 11'd1, 16'hFFFF);
		send_item(KIND_UPDATE, 11'd1024, 16'h1234);
		send_item(KIND_UPDATE, 11'd3, 16'h0000);
		send_item(KIND_QUERY, 11'd2, 16'h0000);
		send_item(KIND_QUERY, 11'd1024, 16'h0000);
		send_item(KIND_QUERY, 11'd2047, 16'hFFFF);  // walk starts past the tree
		send_item(KIND_QUERY, 11'd1025, 16'h0000);
		send_item(KIND_UPDATE, 11'd1500, 16'h0000); // beyond the walk bound
		send_item(KIND_UPDATE, 11'd2047, 16'h0000);
		send_item(KIND_QUERY, 11'd1023, 16'h0000);
		send_item(KIND_UNUSED, 11'd1023, 16'hABCD);
		send_item(KIND_CLEAR, 11'd0, 16'h0000);
		send_item(KIND_QUERY, 11'd1024, 16'h0000);
		send_item(KIND_UPDATE, 11'd512, 16'h8000);
		send_item(KIND_QUERY, 11'd511, 16'h0000);
		send_item(KIND_QUERY, 11'd1024, 16'h0000);

		// A size of zero turns every update into a no-op.
		write_size(11'd0);
		send_item(KIND_UPDATE, 11'd4, 16'h0001);
		send_item(KIND_QUERY, 11'd4, 16'h0000);

		// A size above the tree is treated as the full tree.
		write_size(11'd2047);
		send_item(KIND_UPDATE, 11'd1024, 16'h0005);
		send_item(KIND_QUERY, 11'd2047, 16'h0000);

		// Nodes left valid above a smaller size are still read by queries.
		write_size(11'd8);
		send_item(KIND_UPDATE, 11'd5, 16'h0002);
		write_size(11'd4);
		send_item(KIND_QUERY, 11'd8, 16'h0000);

		// Random phases over a range of sizes.
		run_phase(11'd1, 60, 1'b0);
		run_phase(11'd16, 100, 1'b0);
		calm = 1'b1;
		run_phase(11'd1024, 100, 1'b0);
		calm = 1'b0;
		run_phase(SIZE_W'($urandom_range(1023, 2)), 100, 1'b1);
		run_phase(11'd2047, 80, 1'b0);
		run_phase(11'd1024, 60, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("fenwick_prefix_min_tree verification clean");
		else
			$display("fenwick_prefix_min_tree verification failed");
		$finish;
	end

endmodule
